// ----- sv/bfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bfr_pkg;
    localparam int STORE_BYTES_DEF = 64;
    localparam int FIELD_W = 64;
    localparam int BITS_W = 7;

    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_PEEK  = 3'd1,
        OP_POP   = 3'd2,
        OP_POPS  = 3'd3,
        OP_ALIGN = 3'd4
    } t_op;

    localparam logic REG_BIT_ORDER = 1'b0;
    localparam logic REG_BYTE_DIR  = 1'b1;

    typedef struct packed {
        logic [2:0]        op;
        logic [BITS_W-1:0] field_bits;
        logic [7:0]        load_byte;
    } t_in_word;

    typedef struct packed {
        logic [FIELD_W-1:0] field_value;
        logic               fault;
    } t_out_word;
endpackage
`default_nettype wire

// ----- sv/bfr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- sv/bfr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bfr_front import bfr_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_word i_word,
    output logic          o_q_valid,
    input  wire logic     i_q_ready,
    output t_in_word      o_q_word
);
    // two-entry queue between front and back
    t_in_word   r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_word  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_word;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ----- sv/bfr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bfr_back import bfr_pkg::*; #(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_bit_order,
    input  wire logic     i_byte_dir,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_word i_word,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_out_word     o_word
);
    localparam int AW = $clog2(STORE_BYTES);
    localparam int HW = $clog2(STORE_BYTES + 1);
    localparam int TW = HW + 4;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_DONE} t_state;

    t_state          r_state;
    logic [AW-1:0]   r_front;
    logic [HW-1:0]   r_held;
    logic [2:0]      r_used;
    t_in_word        r_cur;
    logic [3:0]      r_k;
    logic [6:0]      r_got;
    logic [2:0]      r_skip;
    logic            r_rd_pend;
    logic [63:0]     r_acc;
    logic            r_ovalid;
    t_out_word       r_out;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    logic [6:0]      n;
    logic [TW-1:0]   avail;
    logic [TW-1:0]   need;
    logic            enough;
    logic [HW-1:0]   logical;
    logic [AW+HW:0]  phys_sum;
    logic [6:0]      remain;
    logic [3:0]      take;
    logic [3:0]      room;
    logic [7:0]      mask;
    logic [7:0]      chunk;
    logic [63:0]     acc_next;
    logic [63:0]     sext;
    logic [9:0]      total;
    logic [HW-1:0]   whole;
    logic [AW+HW:0]  fsum;
    logic [AW+HW:0]  fadv;
    logic [AW-1:0]   front_adv;
    logic [2:0]      align_n;

    assign n       = r_cur.field_bits;
    assign avail   = {r_held, 3'b000, 1'b0} >> 1;
    assign need    = TW'(r_used) + TW'(n);
    assign enough  = avail >= need;
    assign align_n = 3'(4'd8 - {1'b0, r_used});

    assign logical  = i_byte_dir ? HW'(r_held - HW'(1) - HW'(r_k)) : HW'(r_k);
    assign phys_sum = (AW + HW + 1)'(r_front) + (AW + HW + 1)'(logical);
    assign ram_raddr = (phys_sum >= (AW + HW + 1)'(STORE_BYTES))
                     ? AW'(phys_sum - (AW + HW + 1)'(STORE_BYTES)) : AW'(phys_sum);

    assign fsum = (AW + HW + 1)'(r_front) + (AW + HW + 1)'(r_held);
    assign ram_waddr = (fsum >= (AW + HW + 1)'(STORE_BYTES))
                     ? AW'(fsum - (AW + HW + 1)'(STORE_BYTES)) : AW'(fsum);
    assign ram_we = (r_state == S_DONE) && (r_cur.op == OP_LOAD)
                  && (r_held < HW'(STORE_BYTES));

    bfr_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_cur.load_byte),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // chunk of the byte just read
    assign remain = n - r_got;
    assign room   = 4'd8 - {1'b0, r_skip};
    assign take   = (remain > 7'(room)) ? room : remain[3:0];
    assign mask   = 8'((9'd1 << take) - 9'd1);
    assign chunk  = i_bit_order ? ((ram_rdata >> (4'd8 - take - {1'b0, r_skip})) & mask)
                                : ((ram_rdata >> r_skip) & mask);
    assign acc_next = i_bit_order ? ((r_acc << take) | 64'(chunk))
                                  : (r_acc | (64'(chunk) << r_got));
    assign sext = ((r_cur.op == OP_POPS) && (n < 7'd64) && acc_next[6'(n - 7'd1)])
                ? (acc_next | ({64{1'b1}} << n)) : acc_next;

    assign total = 10'(r_used) + 10'(n);
    assign whole = HW'(total >> 3);

    assign fadv = (AW + HW + 1)'(r_front) + (AW + HW + 1)'(whole);
    assign front_adv = (fadv >= (AW + HW + 1)'(STORE_BYTES))
                     ? AW'(fadv - (AW + HW + 1)'(STORE_BYTES)) : AW'(fadv);

    assign o_ready = (r_state == S_IDLE) && !(r_ovalid && !i_ready);
    assign o_valid = r_ovalid;
    assign o_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_front   <= '0;
            r_held    <= '0;
            r_used    <= '0;
            r_ovalid  <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cur <= i_word;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_out.field_value <= '0;
                    r_out.fault <= 1'b0;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                    case (r_cur.op)
                        OP_LOAD: begin
                            if (r_held < HW'(STORE_BYTES)) begin
                                r_held <= r_held + HW'(1);
                            end else begin
                                r_out.fault <= 1'b1;
                            end
                        end
                        OP_PEEK, OP_POP, OP_POPS: begin
                            if (n > 7'd64 || !enough) begin
                                r_out.fault <= 1'b1;
                            end else if (n != 7'd0) begin
                                r_ovalid <= 1'b0;
                                r_state <= S_READ;
                                r_k <= '0;
                                r_got <= '0;
                                r_skip <= r_used;
                                r_acc <= '0;
                                r_rd_pend <= 1'b0;
                            end
                        end
                        OP_ALIGN: begin
                            if (r_used != 3'd0
                                && avail >= TW'(r_used) + TW'(align_n)) begin
                                r_used <= '0;
                                r_held <= r_held - HW'(1);
                                if (!i_byte_dir) begin
                                    r_front <= AW'((r_front == AW'(STORE_BYTES - 1))
                                        ? '0 : r_front + AW'(1));
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_READ: begin
                    if (!r_rd_pend) begin
                        r_rd_pend <= 1'b1;
                    end else begin
                        r_rd_pend <= 1'b0;
                        r_acc <= acc_next;
                        r_got <= r_got + 7'(take);
                        r_k <= r_k + 4'd1;
                        r_skip <= '0;
                        if (r_got + 7'(take) == n) begin
                            r_out.field_value <= sext;
                            r_out.fault <= 1'b0;
                            r_ovalid <= 1'b1;
                            r_state <= S_IDLE;
                            if (r_cur.op != OP_PEEK) begin
                                r_used <= total[2:0];
                                r_held <= r_held - whole;
                                if (!i_byte_dir) begin
                                    r_front <= front_adv;
                                end
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- sv/bitstream_field_reader.sv -----
// load, align, fault and zero-bit requests need no memory read
// reads do one registered memory read per stored byte spanned
// the back end takes one word at a time, and none while its result is held
// a two-word queue in front lets input be taken while the back end works
// reset (synchronous, active low) empties the store, clears cursor and registers
`timescale 1ns / 1ps
`default_nettype none
module bitstream_field_reader import bfr_pkg::*; #(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in_word    i_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out_word        o_word,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic     r_bit_order;
    logic     r_byte_dir;
    logic     q_valid;
    logic     q_ready;
    t_in_word q_word;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BYTE_DIR) ? {31'd0, r_byte_dir} : {31'd0, r_bit_order};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_order <= 1'b0;
            r_byte_dir  <= 1'b0;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
            if (paddr[2] == REG_BIT_ORDER) begin
                r_bit_order <= pwdata[0];
            end else begin
                r_byte_dir <= pwdata[0];
            end
        end
    end

    bfr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_word    (i_word),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_word  (q_word)
    );

    bfr_back #(.STORE_BYTES(STORE_BYTES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bit_order (r_bit_order),
        .i_byte_dir  (r_byte_dir),
        .i_valid     (q_valid),
        .o_ready     (q_ready),
        .i_word      (q_word),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_word      (o_word)
    );
endmodule
`default_nettype wire

// ----- sv/bfr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bfr_checker import bfr_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire logic      o_ready,
    input wire t_in_word  i_word,
    input wire logic      o_valid,
    input wire logic      i_ready,
    input wire t_out_word o_word,
    input wire logic      pready
);
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_word)) else $error("input dropped");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_word)) else $error("output dropped");
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.fault |-> o_word.field_value == '0) else $error("fault value");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid after reset");
    a_pready: assert property (@(posedge i_clk) pready) else $error("pready low");
endmodule

bind bitstream_field_reader bfr_checker u_bfr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_word  (i_word),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_word  (o_word),
    .pready  (pready)
);
`default_nettype wire

// ----- tb/sv/bitstream_field_reader_tb.sv -----
`timescale 1ns / 1ps
module bitstream_field_reader_tb;
    import bfr_pkg::*;

    localparam int STORE_N = STORE_BYTES_DEF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in_word    i_word = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_word   o_word;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bitstream_field_reader u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_word(i_word),
        .o_valid(o_valid), .i_ready(i_ready), .o_word(o_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [7:0]  mem [STORE_N];
    int unsigned head_pos;
    int unsigned held;
    int unsigned used_bits;
    logic        msb_first;
    logic        from_back;

    t_out_word   expected_q[$];
    int          errors = 0;
    int          hold_off = 0;
    int          burst_len = 0;

    function automatic logic [7:0] byte_at(int unsigned k);
        int unsigned logical;
        logical = from_back ? (held - 1 - k) : k;
        return mem[(head_pos + logical) % STORE_N];
    endfunction

    function automatic bit bits_available(int unsigned n);
        return held * 8 >= used_bits + n;
    endfunction

    function automatic logic [63:0] collect_bits(int unsigned n);
        logic [63:0] acc;
        int unsigned got, k, skip, take;
        logic [7:0] b, chunk;
        acc = '0;
        got = 0;
        k = 0;
        skip = used_bits;
        while (got < n) begin
            take = n - got;
            if (take > 8 - skip) take = 8 - skip;
            b = byte_at(k);
            if (!msb_first) begin
                chunk = 8'((b >> skip) & ((9'd1 << take) - 1));
                acc = acc | (64'(chunk) << got);
            end else begin
                chunk = 8'((b >> (8 - take - skip)) & ((9'd1 << take) - 1));
                acc = (acc << take) | 64'(chunk);
            end
            got += take;
            k++;
            skip = 0;
        end
        return acc;
    endfunction

    function automatic void consume_bits(int unsigned n);
        int unsigned total, whole;
        total = used_bits + n;
        whole = total / 8;
        held -= whole;
        if (!from_back) head_pos = (head_pos + whole) % STORE_N;
        used_bits = total % 8;
    endfunction

    function automatic t_out_word predict_field(t_in_word w);
        t_out_word r;
        int unsigned n;
        r = '0;
        n = int'(w.field_bits);
        case (w.op)
            OP_LOAD: begin
                if (held >= STORE_N) r.fault = 1'b1;
                else begin
                    mem[(head_pos + held) % STORE_N] = w.load_byte;
                    held++;
                end
            end
            OP_PEEK, OP_POP, OP_POPS: begin
                if (n > 64 || !bits_available(n)) r.fault = 1'b1;
                else if (n > 0) begin
                    r.field_value = collect_bits(n);
                    if (w.op == OP_POPS && n < 64 && r.field_value[n-1])
                        r.field_value = r.field_value | (~64'd0 << n);
                    if (w.op != OP_PEEK) consume_bits(n);
                end
            end
            OP_ALIGN: begin
                if (used_bits != 0 && bits_available(8 - used_bits))
                    consume_bits(8 - used_bits);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] addr, input logic value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {31'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 3'(REG_BIT_ORDER * 4)) msb_first = value;
        else from_back = value;
    endtask

    task automatic drain();
        if (burst_len != 0) begin
            i_valid <= 1'b0;
            burst_len = 0;
        end
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic order, input logic dir);
        drain();
        write_reg(3'(REG_BIT_ORDER * 4), order);
        write_reg(3'(REG_BYTE_DIR * 4), dir);
    endtask

    task automatic send_word(input t_in_word w);
        if (burst_len == 0) begin
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
            burst_len = $urandom_range(1, 12);
        end
        burst_len--;
        i_valid <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (!o_ready);
        expected_q.push_back(predict_field(w));
        if (burst_len == 0) i_valid <= 1'b0;
    endtask

    function automatic t_in_word make_word(t_op op, int unsigned n, int unsigned b);
        t_in_word w;
        w.op = op;
        w.field_bits = BITS_W'(n);
        w.load_byte = 8'(b);
        return w;
    endfunction

    task automatic test_directed();
        t_in_word w;
        send_word(make_word(OP_PEEK, 0, 0));
        send_word(make_word(OP_POP, 1, 0));
        send_word(make_word(OP_ALIGN, 127, 255));
        for (int i = 0; i < 9; i++) send_word(make_word(OP_LOAD, 0, 8'h80 + i * 17));
        send_word(make_word(OP_PEEK, 64, 0));
        send_word(make_word(OP_POP, 127, 0));
        send_word(make_word(OP_POP, 3, 0));
        send_word(make_word(OP_ALIGN, 0, 0));
        send_word(make_word(OP_ALIGN, 0, 0));
        send_word(make_word(OP_POPS, 7, 0));
        send_word(make_word(OP_POPS, 64, 0));
        send_word(make_word(OP_POP, 65, 0));
        send_word(make_word(OP_POPS, 1, 0));
        w = '1;
        send_word(w);
        w.op = 3'd5;
        w.field_bits = 0;
        w.load_byte = 0;
        send_word(w);
    endtask

    task automatic test_fill_and_stall();
        hold_off = 300;
        for (int i = 0; i < 66; i++) send_word(make_word(OP_LOAD, 0, $urandom()));
        for (int i = 0; i < 9; i++) send_word(make_word(OP_POP, 64, 0));
        drain();
    endtask

    task automatic test_random(input int count);
        int kind;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 40 || held < 2)
                send_word(make_word(OP_LOAD, $urandom_range(0, 127), $urandom()));
            else if (kind < 88)
                send_word(make_word(t_op'($urandom_range(1, 3)),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                    : $urandom_range(0, (held * 8 - used_bits < 64)
                        ? held * 8 - used_bits : 64),
                    $urandom()));
            else if (kind < 95)
                send_word(make_word(OP_ALIGN, $urandom_range(0, 127), $urandom()));
            else
                send_word(make_word(t_op'($urandom_range(5, 7)), $urandom_range(0, 127),
                    $urandom()));
        end
    endtask

    task automatic test_modes();
        set_mode(1'b1, 1'b0);
        test_directed();
        test_random(250);
        set_mode(1'b0, 1'b1);
        test_random(250);
        set_mode(1'b1, 1'b1);
        test_directed();
        test_random(250);
        // direction change mid-stream, without draining the store
        set_mode(1'b0, 1'b0);
        test_random(250);
    endtask

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
        end
        if (o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                t_out_word e;
                e = expected_q.pop_front();
                if (o_word.field_value !== e.field_value) begin
                    $error("field_value expected %h actual %h", e.field_value,
                        o_word.field_value);
                    errors++;
                end
                if (o_word.fault !== e.fault) begin
                    $error("fault expected %b actual %b", e.fault, o_word.fault);
                    errors++;
                end
            end
        end
    end

    initial begin
        head_pos = 0;
        held = 0;
        used_bits = 0;
        msb_first = 1'b0;
        from_back = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_directed();
        test_fill_and_stall();
        test_modes();
        drain();
        if (errors == 0) $display("bitstream_field_reader: match");
        else $display("bitstream_field_reader: mismatch");
        $finish;
    end

    initial begin
        #400000;
        $display("bitstream_field_reader: mismatch");
        $finish;
    end
endmodule

// ----- sim.f -----
sv/bfr_pkg.sv
sv/bfr_ram.sv
sv/bfr_front.sv
sv/bfr_back.sv
sv/bitstream_field_reader.sv
sv/bfr_checker.sv
tb/sv/bitstream_field_reader_tb.sv
